// ===== src/ghp_pkg.sv =====
// shared types, codes and widths of the generational handle pool
`default_nettype none

package ghp_pkg;

  // default pool size
  localparam int unsigned POOL_SLOTS_DEF = 256;

  // field widths
  localparam int unsigned OP_W         = 3;
  localparam int unsigned HANDLE_W     = 63;
  localparam int unsigned PAYLOAD_W    = 64;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 9;
  localparam int unsigned GEN_W        = 31;
  localparam int unsigned SLOT_FIELD_W = 32;
  localparam int unsigned SLOT_ST_W    = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK   = 3'd1;
  localparam logic [OP_W-1:0] OP_FLUSH  = 3'd2;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STALE = 2'd2;

  // slot states
  localparam logic [SLOT_ST_W-1:0] SLOT_FREE = 2'd0;
  localparam logic [SLOT_ST_W-1:0] SLOT_OCC  = 2'd1;
  localparam logic [SLOT_ST_W-1:0] SLOT_PEND = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic look;
    logic load_look;
    logic walk_start;
    logic walk_step;
    logic load_done;
  } ghp_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [OP_W-1:0] in_op;
    logic [OP_W-1:0] op;
    logic            idx_last;
  } ghp_sts_t;

endpackage

`default_nettype wire

// ===== src/ghp_req_if.sv =====
// request channel of the generational handle pool
`default_nettype none

interface ghp_req_if;
  import ghp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      opcode;
  logic [HANDLE_W-1:0]  handle;
  logic [PAYLOAD_W-1:0] payload_in;

  modport source (output valid, output opcode, output handle, output payload_in, input ready);
  modport sink   (input valid, input opcode, input handle, input payload_in, output ready);
endinterface

`default_nettype wire

// ===== src/ghp_rsp_if.sv =====
// response channel of the generational handle pool
`default_nettype none

interface ghp_rsp_if;
  import ghp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [HANDLE_W-1:0]  handle_out;
  logic [PAYLOAD_W-1:0] payload_out;
  logic [COUNT_W-1:0]   freed_count;

  modport source (output valid, output status, output handle_out, output payload_out,
                  output freed_count, input ready);
  modport sink   (input valid, input status, input handle_out, input payload_out,
                  input freed_count, output ready);
endinterface

`default_nettype wire

// ===== src/generational_handle_pool.sv =====
// generational handle pool: fixed slot pool with a LIFO free list
//
// requests arrive on req_i (opcode, handle, payload_in), one response per
// request leaves on rsp_o (status, handle_out, payload_out, freed_count);
// a transfer happens on a clock edge with valid and ready both high.
// allocate, mark and query read the addressed slot in the cycle of the
// transfer and write it back in the look step, which waits for a free
// output register and loads the response into it. flush walks every slot
// through the single read port of the slot memory, one slot per cycle;
// remove first marks its slot as mark does, then walks as flush does.
// one item is in work at a time; a request is taken while the previous
// response still waits in the output register, and the block holds in its
// last step until the receiver takes that response.
// after reset the block clears the slot state and links the free list,
// one slot per cycle, with req_i.ready low.
`default_nettype none

module generational_handle_pool #(
  parameter int unsigned POOL_SLOTS = ghp_pkg::POOL_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ghp_req_if.sink    req_i,
  ghp_rsp_if.source  rsp_o
);
  import ghp_pkg::*;

  ghp_cmd_t cmd;
  ghp_sts_t sts;

  // sequencer
  ghp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sts_i       (sts),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  // slot storage and result path
  ghp_datapath #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (req_i.opcode),
    .handle_i      (req_i.handle),
    .payload_in_i  (req_i.payload_in),
    .status_o      (rsp_o.status),
    .handle_out_o  (rsp_o.handle_out),
    .payload_out_o (rsp_o.payload_out),
    .freed_count_o (rsp_o.freed_count)
  );

endmodule

`default_nettype wire

// ===== src/ghp_ctrl.sv =====
// sequencing state machine of the generational handle pool
`default_nettype none

module ghp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ghp_pkg::ghp_sts_t sts_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ghp_pkg::ghp_cmd_t cmd_o
);
  import ghp_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_WSTART,
    S_WALK,
    S_DONE
  } state_e;

  state_e   state_q, state_d;
  logic     out_valid_q, out_valid_d;
  logic     out_free;
  ghp_cmd_t cmd;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts_i.idx_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          case (sts_i.in_op)
            OP_ALLOC, OP_MARK, OP_REMOVE, OP_QUERY: state_d = S_LOOK;
            OP_FLUSH: state_d = S_WSTART;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_LOOK: begin
        if (sts_i.op == OP_REMOVE) begin
          cmd.look = 1'b1;
          state_d  = S_WSTART;
        end else if (out_free) begin
          cmd.look      = 1'b1;
          cmd.load_look = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_WSTART: begin
        cmd.walk_start = 1'b1;
        state_d        = S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts_i.idx_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_done = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/ghp_datapath.sv =====
// slot memories, free list head, walk counter and result registers
`default_nettype none

module ghp_datapath #(
  parameter int unsigned POOL_SLOTS = ghp_pkg::POOL_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ghp_pkg::ghp_cmd_t              cmd_i,
  output ghp_pkg::ghp_sts_t              sts_o,
  input  logic [ghp_pkg::OP_W-1:0]       opcode_i,
  input  logic [ghp_pkg::HANDLE_W-1:0]   handle_i,
  input  logic [ghp_pkg::PAYLOAD_W-1:0]  payload_in_i,
  output logic [ghp_pkg::STATUS_W-1:0]   status_o,
  output logic [ghp_pkg::HANDLE_W-1:0]   handle_out_o,
  output logic [ghp_pkg::PAYLOAD_W-1:0]  payload_out_o,
  output logic [ghp_pkg::COUNT_W-1:0]    freed_count_o
);
  import ghp_pkg::*;

  localparam int unsigned IW     = $clog2(POOL_SLOTS);
  localparam int unsigned SW     = $clog2(POOL_SLOTS + 1);
  localparam int unsigned META_W = SLOT_ST_W + GEN_W;

  // captured item
  logic [OP_W-1:0]      op_q;
  logic [HANDLE_W-1:0]  handle_q;
  logic [PAYLOAD_W-1:0] pin_q;
  logic [IW-1:0]        addr_q;
  logic                 in_range_q;
  logic                 full_q;

  // control state
  logic [SW-1:0]        head_q;
  logic [IW-1:0]        idx_q;
  logic [COUNT_W-1:0]   freed_q;
  logic [STATUS_W-1:0]  status_q;
  logic                 idx_last;

  // memories and their ports
  logic [META_W-1:0]    meta_mem [POOL_SLOTS];
  logic [SW-1:0]        link_mem [POOL_SLOTS];
  logic [PAYLOAD_W-1:0] pay_mem  [POOL_SLOTS];
  logic [META_W-1:0]    meta_rd_q;
  logic [SW-1:0]        link_rd_q;
  logic [PAYLOAD_W-1:0] pay_rd_q;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic                 meta_we;
  logic [IW-1:0]        meta_wa;
  logic [META_W-1:0]    meta_wd;
  logic                 link_we;
  logic [SW-1:0]        link_wd;
  logic                 pay_we;

  // decoded read data
  logic [SLOT_ST_W-1:0] rd_st;
  logic [GEN_W-1:0]     rd_gen;
  logic [GEN_W-1:0]     gen_inc;
  logic                 hit;
  logic                 pend;

  // lookup result
  logic [STATUS_W-1:0]  look_status;
  logic [HANDLE_W-1:0]  look_handle;
  logic [PAYLOAD_W-1:0] look_payload;

  // output register
  logic [STATUS_W-1:0]  out_status_q;
  logic [HANDLE_W-1:0]  out_handle_q;
  logic [PAYLOAD_W-1:0] out_payload_q;
  logic [COUNT_W-1:0]   out_freed_q;

  assign rd_st    = meta_rd_q[META_W-1 -: SLOT_ST_W];
  assign rd_gen   = meta_rd_q[GEN_W-1:0];
  assign gen_inc  = rd_gen + GEN_W'(1);
  assign hit      = in_range_q && (rd_st == SLOT_OCC)
                    && (rd_gen == handle_q[HANDLE_W-1 -: GEN_W]);
  assign pend     = (rd_st == SLOT_PEND);
  assign idx_last = (idx_q == IW'(POOL_SLOTS - 1));

  assign sts_o.in_op    = opcode_i;
  assign sts_o.op       = op_q;
  assign sts_o.idx_last = idx_last;

  // result of the single-slot operations
  always_comb begin
    look_status  = ST_OK;
    look_handle  = '0;
    look_payload = '0;
    case (op_q)
      OP_ALLOC: begin
        if (full_q) look_status = ST_FULL;
        else        look_handle = {gen_inc, SLOT_FIELD_W'(addr_q)};
      end
      OP_MARK, OP_REMOVE: begin
        if (!hit) look_status = ST_STALE;
      end
      OP_QUERY: begin
        if (hit) begin
          look_handle  = {GEN_W'(0), handle_q[SLOT_FIELD_W-1:0]};
          look_payload = pay_rd_q;
        end else begin
          look_status = ST_STALE;
        end
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    meta_we = 1'b0;
    meta_wa = addr_q;
    meta_wd = {SLOT_FREE, rd_gen};
    link_we = 1'b0;
    link_wd = head_q;
    pay_we  = 1'b0;
    rd_en   = 1'b0;
    rd_addr = idx_q + IW'(1);

    // clearing pass after reset
    if (cmd_i.clear_step) begin
      meta_we = 1'b1;
      meta_wa = idx_q;
      meta_wd = {SLOT_FREE, GEN_W'(0)};
      link_we = 1'b1;
      link_wd = SW'(idx_q) + SW'(1);
    end

    // read-modify-write of the addressed slot
    if (cmd_i.look) begin
      case (op_q)
        OP_ALLOC: begin
          if (!full_q) begin
            meta_we = 1'b1;
            meta_wd = {SLOT_OCC, gen_inc};
            pay_we  = 1'b1;
          end
        end
        OP_MARK, OP_REMOVE: begin
          if (hit) begin
            meta_we = 1'b1;
            meta_wd = {SLOT_PEND, rd_gen};
          end
        end
        default: ;
      endcase
    end

    // flush walk: free a pending slot and push it on the list
    if (cmd_i.walk_step && pend) begin
      meta_we = 1'b1;
      meta_wa = idx_q;
      meta_wd = {SLOT_FREE, rd_gen};
      link_we = 1'b1;
      link_wd = head_q;
    end

    // reads
    if (cmd_i.accept) begin
      rd_en   = 1'b1;
      rd_addr = (opcode_i == OP_ALLOC) ? head_q[IW-1:0] : handle_i[IW-1:0];
    end
    if (cmd_i.walk_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
    if (cmd_i.walk_step && !idx_last) begin
      rd_en   = 1'b1;
      rd_addr = idx_q + IW'(1);
    end
  end

  // slot state and generation
  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (rd_en)   meta_rd_q <= meta_mem[rd_addr];
  end

  // free list links
  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[idx_q] <= link_wd;
    if (rd_en)   link_rd_q <= link_mem[rd_addr];
  end

  // payload words
  always_ff @(posedge clk_i) begin
    if (pay_we) pay_mem[addr_q] <= pin_q;
    if (rd_en)  pay_rd_q <= pay_mem[rd_addr];
  end

  // free list head, walk counter and freed count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      idx_q   <= '0;
      freed_q <= '0;
    end else begin
      if (cmd_i.clear_step) idx_q <= idx_q + IW'(1);
      if (cmd_i.accept) freed_q <= '0;
      if (cmd_i.walk_start) begin
        idx_q   <= '0;
        freed_q <= '0;
      end
      if (cmd_i.walk_step) begin
        idx_q <= idx_q + IW'(1);
        if (pend) begin
          head_q  <= SW'(idx_q);
          freed_q <= freed_q + COUNT_W'(1);
        end
      end
      if (cmd_i.look && (op_q == OP_ALLOC) && !full_q) head_q <= link_rd_q;
    end
  end

  // item capture and status of a remove or flush
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q       <= opcode_i;
      handle_q   <= handle_i;
      pin_q      <= payload_in_i;
      addr_q     <= (opcode_i == OP_ALLOC) ? head_q[IW-1:0] : handle_i[IW-1:0];
      in_range_q <= (handle_i[SLOT_FIELD_W-1:0] < SLOT_FIELD_W'(POOL_SLOTS));
      full_q     <= (head_q == SW'(POOL_SLOTS));
      status_q   <= ST_OK;
    end
    if (cmd_i.look) status_q <= look_status;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_look) begin
      out_status_q  <= look_status;
      out_handle_q  <= look_handle;
      out_payload_q <= look_payload;
      out_freed_q   <= '0;
    end
    if (cmd_i.load_done) begin
      out_status_q  <= status_q;
      out_handle_q  <= '0;
      out_payload_q <= '0;
      out_freed_q   <= freed_q;
    end
  end

  assign status_o      = out_status_q;
  assign handle_out_o  = out_handle_q;
  assign payload_out_o = out_payload_q;
  assign freed_count_o = out_freed_q;

endmodule

`default_nettype wire

// ===== tb/tb_generational_handle_pool.sv =====
// testbench of the generational handle pool: directed and random pool traffic against a slot map
`timescale 1ns / 100ps

module tb_generational_handle_pool;
  import ghp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned ITEM_TARGET = 800;
  localparam int unsigned HOLD_AFTER  = 450;
  localparam int unsigned HOLD_CYCLES = 400;

  // opcodes five to seven have no operation behind them
  localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [HANDLE_W-1:0]  handle;
    logic [PAYLOAD_W-1:0] payload;
  } pool_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [HANDLE_W-1:0]  handle_out;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [COUNT_W-1:0]   freed_count;
  } pool_rsp_t;

  typedef enum int {MODE_FILL, MODE_MIX, MODE_DRAIN} traffic_mode_e;

  // slot map mirror: predicts every response and keeps the ones still owed
  class slot_map_tracker;
    logic [SLOT_ST_W-1:0] slot_state [POOL_SLOTS_DEF];
    logic [GEN_W-1:0]     slot_gen   [POOL_SLOTS_DEF];
    logic [PAYLOAD_W-1:0] slot_data  [POOL_SLOTS_DEF];
    int unsigned          next_link  [POOL_SLOTS_DEF];
    int unsigned          free_head;
    pool_rsp_t            owed_rsp[$];
    int unsigned          mismatches;
    int unsigned          rsp_seen;

    function new();
      for (int unsigned i = 0; i < POOL_SLOTS_DEF; i++) begin
        slot_state[i] = SLOT_FREE;
        slot_gen[i]   = '0;
        slot_data[i]  = '0;
        next_link[i]  = i + 1;
      end
      free_head  = 0;
      mismatches = 0;
      rsp_seen   = 0;
    endfunction

    // slot of a live handle, or POOL_SLOTS_DEF when the handle is not live
    function int unsigned live_slot(logic [HANDLE_W-1:0] h);
      logic [SLOT_FIELD_W-1:0] s;
      s = h[SLOT_FIELD_W-1:0];
      if (s >= POOL_SLOTS_DEF) return POOL_SLOTS_DEF;
      if (slot_state[s] != SLOT_OCC) return POOL_SLOTS_DEF;
      if (slot_gen[s] != h[HANDLE_W-1:SLOT_FIELD_W]) return POOL_SLOTS_DEF;
      return int'(s);
    endfunction

    // ascending walk: the highest freed slot ends at the head
    function int unsigned flush_pending();
      int unsigned freed;
      freed = 0;
      for (int unsigned i = 0; i < POOL_SLOTS_DEF; i++) begin
        if (slot_state[i] == SLOT_PEND) begin
          slot_state[i] = SLOT_FREE;
          next_link[i]  = free_head;
          free_head     = i;
          freed++;
        end
      end
      return freed;
    endfunction

    function pool_rsp_t pool_outcome(pool_req_t r);
      pool_rsp_t   o;
      int unsigned s;
      o = '0;
      case (r.op)
        OP_ALLOC: begin
          if (free_head >= POOL_SLOTS_DEF) begin
            o.status = ST_FULL;
          end else begin
            s = free_head;
            free_head     = next_link[s];
            slot_data[s]  = r.payload;
            slot_state[s] = SLOT_OCC;
            // 31-bit generation wraps to zero by itself
            slot_gen[s]   = slot_gen[s] + 1'b1;
            o.handle_out  = {slot_gen[s], SLOT_FIELD_W'(s)};
          end
        end
        OP_MARK, OP_REMOVE: begin
          s = live_slot(r.handle);
          if (s >= POOL_SLOTS_DEF) o.status = ST_STALE;
          else slot_state[s] = SLOT_PEND;
          if (r.op == OP_REMOVE) o.freed_count = COUNT_W'(flush_pending());
        end
        OP_FLUSH: begin
          o.freed_count = COUNT_W'(flush_pending());
        end
        OP_QUERY: begin
          s = live_slot(r.handle);
          if (s >= POOL_SLOTS_DEF) begin
            o.status = ST_STALE;
          end else begin
            o.handle_out  = HANDLE_W'(s);
            o.payload_out = slot_data[s];
          end
        end
        default: ;
      endcase
      return o;
    endfunction

    function void note_request(pool_req_t r);
      owed_rsp.insert(owed_rsp.size(), pool_outcome(r));
    endfunction

    task report(string what);
      $display("mismatch at response %0d: %s", rsp_seen, what);
      mismatches++;
    endtask

    task check_response(pool_rsp_t got);
      pool_rsp_t want;
      rsp_seen++;
      if (owed_rsp.size() == 0) begin
        report("response with none outstanding");
      end else begin
        want = owed_rsp.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0h, want %0h", got.status, want.status));
        if (got.handle_out !== want.handle_out)
          report($sformatf("handle_out %0h, want %0h", got.handle_out, want.handle_out));
        if (got.payload_out !== want.payload_out)
          report($sformatf("payload_out %0h, want %0h", got.payload_out, want.payload_out));
        if (got.freed_count !== want.freed_count)
          report($sformatf("freed_count %0d, want %0d", got.freed_count, want.freed_count));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  ghp_req_if req ();
  ghp_rsp_if rsp ();

  generational_handle_pool #(
    .POOL_SLOTS(POOL_SLOTS_DEF)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rsp_o (rsp)
  );

  slot_map_tracker sb;
  int unsigned     items_sent = 0;
  int unsigned     cycle_count = 0;
  logic            tx_calm = 1'b0;
  logic            rsp_hold = 1'b0;
  int unsigned     rx_stall = 0;
  int unsigned     rx_window = 0;
  logic            rx_calm = 1'b0;

  always #4 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d responses outstanding", sb.owed_rsp.size());
      $display("FAILURE");
      $finish;
    end
  end

  // response side: check each transfer, then pick ready for the next edge
  always @(posedge clk_i) begin
    int unsigned roll;
    if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
      sb.check_response({rsp.status, rsp.handle_out, rsp.payload_out, rsp.freed_count});
    if (rx_window == 0) begin
      rx_window = $urandom_range(300, 50);
      rx_calm   = ($urandom_range(3) == 0);
    end else begin
      rx_window--;
    end
    roll = $urandom_range(99);
    if (rsp_hold) begin
      rsp.ready <= 1'b0;
    end else if (rx_stall != 0) begin
      rx_stall--;
      rsp.ready <= 1'b0;
    end else if (rx_calm || roll < 70) begin
      rsp.ready <= 1'b1;
    end else begin
      rx_stall = (roll < 95) ? $urandom_range(2) : $urandom_range(50, 10);
      rsp.ready <= 1'b0;
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    while (items_sent < HOLD_AFTER) @(posedge clk_i);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rsp_hold <= 1'b0;
  end

  function automatic logic [PAYLOAD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic pool_req_t make_req(logic [OP_W-1:0] op, logic [HANDLE_W-1:0] h,
                                         logic [PAYLOAD_W-1:0] p);
    pool_req_t r;
    r.op      = op;
    r.handle  = h;
    r.payload = p;
    return r;
  endfunction

  function automatic logic [HANDLE_W-1:0] handle_of(int unsigned s);
    return {sb.slot_gen[s], SLOT_FIELD_W'(s)};
  endfunction

  // some slot in the given state, from a random start, or POOL_SLOTS_DEF
  function automatic int unsigned slot_in_state(logic [SLOT_ST_W-1:0] st);
    int unsigned start;
    int unsigned s;
    start = $urandom_range(POOL_SLOTS_DEF - 1);
    for (int unsigned i = 0; i < POOL_SLOTS_DEF; i++) begin
      s = (start + i) % POOL_SLOTS_DEF;
      if (sb.slot_state[s] == st) return s;
    end
    return POOL_SLOTS_DEF;
  endfunction

  // mostly live handles, then pending, stale, out of range and noise
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int unsigned             roll;
    int unsigned             s;
    logic [SLOT_FIELD_W-1:0] far;
    roll = $urandom_range(99);
    if (roll < 70) begin
      s = slot_in_state(SLOT_OCC);
      if (s < POOL_SLOTS_DEF) return handle_of(s);
    end
    if (roll < 76) begin
      s = slot_in_state(SLOT_PEND);
      if (s < POOL_SLOTS_DEF) return handle_of(s);
    end
    if (roll < 84) begin
      s = $urandom_range(POOL_SLOTS_DEF - 1);
      return {sb.slot_gen[s] ^ (GEN_W'(1) << $urandom_range(GEN_W - 1)), SLOT_FIELD_W'(s)};
    end
    if (roll < 92) begin
      if ($urandom_range(1) == 0)
        far = SLOT_FIELD_W'(POOL_SLOTS_DEF + $urandom_range(3));
      else
        far = $urandom | (SLOT_FIELD_W'(1) << $urandom_range(SLOT_FIELD_W - 1, 8));
      return {GEN_W'($urandom), far};
    end
    return HANDLE_W'(rand_word());
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned roll;
    if (tx_calm) return 0;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic pool_req_t random_req(traffic_mode_e mode);
    int unsigned w_alloc, w_mark, w_remove, w_query, w_flush;
    int unsigned roll;
    logic [OP_W-1:0] op;
    case (mode)
      MODE_FILL:  begin w_alloc = 80; w_mark = 5;  w_remove = 3;  w_query = 8;  w_flush = 2; end
      MODE_MIX:   begin w_alloc = 30; w_mark = 20; w_remove = 10; w_query = 30; w_flush = 6; end
      default:    begin w_alloc = 8;  w_mark = 50; w_remove = 15; w_query = 17; w_flush = 6; end
    endcase
    roll = $urandom_range(99);
    if (roll < w_alloc)
      return make_req(OP_ALLOC, HANDLE_W'(rand_word()), rand_word());
    roll -= w_alloc;
    if (roll < w_mark)
      return make_req(OP_MARK, pick_handle(), rand_word());
    roll -= w_mark;
    if (roll < w_remove)
      return make_req(OP_REMOVE, pick_handle(), rand_word());
    roll -= w_remove;
    if (roll < w_query)
      return make_req(OP_QUERY, pick_handle(), rand_word());
    roll -= w_query;
    if (roll < w_flush)
      return make_req(OP_FLUSH, HANDLE_W'(rand_word()), rand_word());
    op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
    return make_req(op, HANDLE_W'(rand_word()), rand_word());
  endfunction

  // one request transfer, then an optional gap with valid low
  task automatic send_req(input pool_req_t r);
    int unsigned gap;
    req.valid      <= 1'b1;
    req.opcode     <= r.op;
    req.handle     <= r.handle;
    req.payload_in <= r.payload;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    sb.note_request(r);
    items_sent++;
    if (items_sent % 32 == 0) tx_calm = ($urandom_range(3) == 0);
    gap = sender_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // field extremes, every operation and the stale-handle corners
  task automatic run_directed();
    send_req(make_req(OP_QUERY, '0, '1));                        // nothing allocated yet
    send_req(make_req(OP_ALLOC, '1, '1));                        // slot 0, generation 1
    send_req(make_req(OP_ALLOC, '0, '0));                        // slot 1
    send_req(make_req(OP_QUERY, handle_of(0), '0));
    send_req(make_req(OP_QUERY, handle_of(1), '1));
    send_req(make_req(OP_QUERY, handle_of(0) ^ (HANDLE_W'(1) << SLOT_FIELD_W), '0));
    send_req(make_req(OP_QUERY, {{GEN_W{1'b1}}, SLOT_FIELD_W'(0)}, '0));
    send_req(make_req(OP_QUERY, '1, '0));                        // slot field at its maximum
    send_req(make_req(OP_MARK, {GEN_W'(1), SLOT_FIELD_W'(POOL_SLOTS_DEF)}, '0));
    send_req(make_req(OP_MARK, handle_of(0), '1));
    send_req(make_req(OP_MARK, handle_of(0), '0));               // already pending
    send_req(make_req(OP_QUERY, handle_of(0), '0));              // pending is not live
    send_req(make_req(OP_FLUSH, '1, '1));
    send_req(make_req(OP_FLUSH, '0, '0));                        // nothing left to free
    send_req(make_req(OP_ALLOC, '0, 64'h5A5A_A5A5_0F0F_F0F0));   // slot 0 again, generation 2
    send_req(make_req(OP_REMOVE, handle_of(1), '0));
    send_req(make_req(OP_REMOVE, handle_of(1), '0));             // slot 1 now free
    send_req(make_req(OP_MARK, handle_of(0), '0));
    send_req(make_req(OP_REMOVE, '1, '0));                       // bad handle, flush still frees
    for (int unsigned op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_req(make_req(OP_W'(op), '1, '1));
    // generation wrap needs 2^31 allocations of one slot and stays out of reach
  endtask

  initial begin
    traffic_mode_e mode;
    int unsigned   burst;
    int unsigned   roll;

    sb             = new();
    rst_ni         = 1'b0;
    req.valid      = 1'b0;
    req.opcode     = OP_ALLOC;
    req.handle     = '0;
    req.payload_in = '0;
    rsp.ready      = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    // allocation-heavy traffic until the free list runs dry
    while (sb.free_head < POOL_SLOTS_DEF) send_req(random_req(MODE_FILL));
    repeat (3) send_req(make_req(OP_ALLOC, HANDLE_W'(rand_word()), rand_word()));

    // mark every live slot, then one flush frees the whole pool
    for (int unsigned s = 0; s < POOL_SLOTS_DEF; s++)
      if (sb.slot_state[s] == SLOT_OCC) send_req(make_req(OP_MARK, handle_of(s), rand_word()));
    send_req(make_req(OP_FLUSH, HANDLE_W'(rand_word()), rand_word()));

    // mixed bursts
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(99);
      mode = (roll < 35) ? MODE_FILL : (roll < 80) ? MODE_MIX : MODE_DRAIN;
      burst = $urandom_range(60, 20);
      repeat (burst) send_req(random_req(mode));
    end
    req.valid <= 1'b0;

    // drain, then allow for a trailing flush
    while (sb.owed_rsp.size() != 0) @(posedge clk_i);
    repeat (POOL_SLOTS_DEF + 20) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
